// ===== rtl/core/tasp_pkg.sv =====
package tasp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REC_ENTRY = 2'd0,
    REC_DATA  = 2'd1,
    REC_END   = 2'd2
  } rec_kind_e;

  // header byte offsets
  localparam logic [8:0] MODE_FIRST  = 9'd100;
  localparam logic [8:0] MODE_LAST   = 9'd107;
  localparam logic [8:0] SIZE_FIRST  = 9'd124;
  localparam logic [8:0] SIZE_LAST   = 9'd135;
  localparam logic [8:0] CKSUM_FIRST = 9'd148;
  localparam logic [8:0] CKSUM_LAST  = 9'd155;
  localparam logic [8:0] TYPE_OFFSET = 9'd156;
  localparam logic [8:0] BLOCK_LAST  = 9'd511;

  localparam logic [7:0]  TYPE_DIR     = 8'h35;
  localparam logic [7:0]  TYPE_SYMLINK = 8'h32;
  localparam logic [7:0]  ASCII_SPACE  = 8'h20;
  localparam logic [23:0] DIR_MODE     = 24'o755;
  localparam logic [23:0] FILE_MODE    = 24'o644;
  localparam logic [19:0] COUNT_MAX    = 20'hFFFFF;

  typedef struct packed {
    logic [8:0]  offset;
    phase_e      phase;
    logic [35:0] size;
    logic        size_open;
    logic [23:0] mode;
    logic        mode_open;
    logic [7:0]  type_byte;
    logic [16:0] sum;
    logic        name_empty;
    logic [8:0]  pad_left;
    logic [35:0] content_left;
    logic [19:0] entry_total;
  } tasp_state_t;

  // header phase at offset 0, both field parsers open
  localparam tasp_state_t STATE_RESET = '{
    offset:       9'd0,
    phase:        PH_HEADER,
    size:         36'd0,
    size_open:    1'b1,
    mode:         24'd0,
    mode_open:    1'b1,
    type_byte:    8'd0,
    sum:          17'd0,
    name_empty:   1'b0,
    pad_left:     9'd0,
    content_left: 36'd0,
    entry_total:  20'd0
  };

  typedef struct packed {
    logic        valid;
    rec_kind_e   kind;
    logic [7:0]  entry_type;
    logic [35:0] file_size;
    logic [23:0] mode;
    logic [16:0] sum;
    logic [7:0]  data;
    logic        last;
    logic [19:0] entries;
  } tasp_result_t;

endpackage

// ===== rtl/core/tar_archive_stream_parser.sv =====
// A result word is registered and appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle while in_stall_o is low; the per-byte parse step sits between the
// parser state registers and a single output register.
// in_stall_o is high only while the output register is full and stalled.
// Reset (rst_ni low, asynchronous): header phase at block offset 0, count zero,
// extract_mode cleared, output register empty.
module tar_archive_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  archive_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  record_kind_o,
  output logic [7:0]  entry_type_o,
  output logic [35:0] file_size_o,
  output logic [23:0] effective_mode_o,
  output logic [16:0] header_sum_o,
  output logic [7:0]  data_byte_o,
  output logic        last_of_file_o,
  output logic [19:0] entries_seen_o
);

  tasp_pkg::tasp_state_t  state_q;
  tasp_pkg::tasp_state_t  state_d;
  tasp_pkg::tasp_result_t result;
  tasp_pkg::tasp_result_t res_q;
  logic                   extract_q;
  logic                   out_valid_q;
  logic                   out_valid_d;
  logic                   out_free;
  logic                   in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_accept  = in_valid_i && out_free;

  tasp_step u_step (
    .state_i   (state_q),
    .byte_i    (archive_byte_i),
    .extract_i (extract_q),
    .state_o   (state_d),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = in_accept && result.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tasp_pkg::STATE_RESET;
      extract_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        extract_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && result.valid) begin
      res_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign record_kind_o    = res_q.kind;
  assign entry_type_o     = res_q.entry_type;
  assign file_size_o      = res_q.file_size;
  assign effective_mode_o = res_q.mode;
  assign header_sum_o     = res_q.sum;
  assign data_byte_o      = res_q.data;
  assign last_of_file_o   = res_q.last;
  assign entries_seen_o   = res_q.entries;

endmodule

// ===== rtl/core/tasp_step.sv =====
module tasp_step (
  input  tasp_pkg::tasp_state_t  state_i,
  input  logic [7:0]             byte_i,
  input  logic                   extract_i,
  output tasp_pkg::tasp_state_t  state_o,
  output tasp_pkg::tasp_result_t result_o
);

  tasp_pkg::tasp_state_t base;
  tasp_pkg::tasp_state_t nxt;
  logic [35:0] content_dec;
  logic        is_octal;
  logic        in_cksum;
  logic        in_mode;
  logic        in_size;
  logic        regular;

  assign content_dec = state_i.content_left - 36'd1;
  // '0'..'7' are 0x30..0x37
  assign is_octal    = (byte_i[7:3] == 5'b00110);
  assign in_cksum    = (state_i.offset >= tasp_pkg::CKSUM_FIRST) &&
                       (state_i.offset <= tasp_pkg::CKSUM_LAST);
  assign in_mode     = (state_i.offset >= tasp_pkg::MODE_FIRST) &&
                       (state_i.offset <= tasp_pkg::MODE_LAST);
  assign in_size     = (state_i.offset >= tasp_pkg::SIZE_FIRST) &&
                       (state_i.offset <= tasp_pkg::SIZE_LAST);
  assign regular     = (state_i.type_byte != tasp_pkg::TYPE_DIR) &&
                       (state_i.type_byte != tasp_pkg::TYPE_SYMLINK);

  // first byte of a header block restarts the field parsers
  always_comb begin
    base = state_i;
    if (state_i.offset == 9'd0) begin
      base.size       = '0;
      base.size_open  = 1'b1;
      base.mode       = '0;
      base.mode_open  = 1'b1;
      base.type_byte  = '0;
      base.sum        = '0;
      base.name_empty = (byte_i == 8'd0);
    end
  end

  always_comb begin
    nxt      = state_i;
    result_o = '0;
    case (state_i.phase)
      tasp_pkg::PH_DATA: begin
        if (state_i.content_left != 36'd0) begin
          nxt.content_left = content_dec;
          if ((content_dec == 36'd0) && (state_i.pad_left == 9'd0)) begin
            nxt.phase = tasp_pkg::PH_HEADER;
          end
          if (extract_i && regular) begin
            result_o.valid = 1'b1;
            result_o.kind  = tasp_pkg::REC_DATA;
            result_o.data  = byte_i;
            result_o.last  = (content_dec == 36'd0);
          end
        end else begin
          if (state_i.pad_left != 9'd0) begin
            nxt.pad_left = state_i.pad_left - 9'd1;
          end
          if (state_i.pad_left <= 9'd1) begin
            nxt.phase = tasp_pkg::PH_HEADER;
          end
        end
      end
      tasp_pkg::PH_HEADER: begin
        nxt     = base;
        nxt.sum = base.sum + {9'd0, (in_cksum ? tasp_pkg::ASCII_SPACE : byte_i)};
        if (in_mode && base.mode_open) begin
          if (is_octal) begin
            nxt.mode = {base.mode[20:0], byte_i[2:0]};
          end else begin
            nxt.mode_open = 1'b0;
          end
        end
        if (in_size && base.size_open) begin
          if (is_octal) begin
            nxt.size = {base.size[32:0], byte_i[2:0]};
          end else begin
            nxt.size_open = 1'b0;
          end
        end
        if (state_i.offset == tasp_pkg::TYPE_OFFSET) begin
          nxt.type_byte = byte_i;
        end
        if (state_i.offset == tasp_pkg::BLOCK_LAST) begin
          nxt.offset = 9'd0;
          if (base.name_empty) begin
            nxt.phase = tasp_pkg::PH_DONE;
          end else begin
            if (state_i.entry_total != tasp_pkg::COUNT_MAX) begin
              nxt.entry_total = state_i.entry_total + 20'd1;
            end
            nxt.content_left = nxt.size;
            // padding up to the next block boundary
            nxt.pad_left = 9'd0 - nxt.size[8:0];
            if ((nxt.size != 36'd0) || (nxt.pad_left != 9'd0)) begin
              nxt.phase = tasp_pkg::PH_DATA;
            end
          end
        end else begin
          nxt.offset = state_i.offset + 9'd1;
        end
        if (state_i.offset == tasp_pkg::BLOCK_LAST) begin
          result_o.valid = 1'b1;
          result_o.kind  = base.name_empty ? tasp_pkg::REC_END : tasp_pkg::REC_ENTRY;
        end
      end
      default: begin
        // archive finished: bytes are dropped
      end
    endcase

    if (result_o.kind != tasp_pkg::REC_END) begin
      result_o.entry_type = nxt.type_byte;
      result_o.file_size  = nxt.size;
      result_o.sum        = nxt.sum;
      if (nxt.mode != 24'd0) begin
        result_o.mode = nxt.mode;
      end else if (nxt.type_byte == tasp_pkg::TYPE_DIR) begin
        result_o.mode = tasp_pkg::DIR_MODE;
      end else begin
        result_o.mode = tasp_pkg::FILE_MODE;
      end
    end
    result_o.entries = nxt.entry_total;
    state_o = nxt;
  end

endmodule

// ===== rtl/core/tasp_checker.sv =====
module tasp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  record_kind_o,
  input logic [35:0] file_size_o,
  input logic [23:0] effective_mode_o,
  input logic [16:0] header_sum_o,
  input logic [7:0]  data_byte_o,
  input logic        last_of_file_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(record_kind_o) &&
      $stable(data_byte_o) && $stable(file_size_o))
    else $error("output word changed under stall");

  // input only backs up behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting output word");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == tasp_pkg::REC_END) |->
      (file_size_o == 36'd0) && (header_sum_o == 17'd0) &&
      (effective_mode_o == 24'd0) && (data_byte_o == 8'd0) && !last_of_file_o)
    else $error("end record carries entry fields");

  a_last_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_file_o |-> (record_kind_o == tasp_pkg::REC_DATA))
    else $error("last flag outside a data word");

endmodule

bind tar_archive_stream_parser tasp_checker u_tasp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .record_kind_o    (record_kind_o),
  .file_size_o      (file_size_o),
  .effective_mode_o (effective_mode_o),
  .header_sum_o     (header_sum_o),
  .data_byte_o      (data_byte_o),
  .last_of_file_o   (last_of_file_o)
);
